/* rtl/core/tcnn_pkg.sv */
// Shared types, constants and arithmetic helpers of the temporal CNN front end.
// Depends on nothing; all files but the interfaces and the RAM import it.
`timescale 1ns / 1ps

package tcnn_pkg;

  localparam int ACC_W = 48;
  localparam int Q_W   = ACC_W - 12;

  localparam logic CMD_WEIGHT = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic signed [15:0] Q_ONE = 16'sd4096;

  typedef enum logic [1:0] {
    LAYER_TEMP,
    LAYER_MIX,
    LAYER_DEPTH,
    LAYER_PROJ
  } layer_t;

  typedef struct packed {
    logic   weight_we;
    logic   sample_we;
    logic   sample_shift;
    logic   issue;
    logic   is_bias;
    logic   last_term;
    layer_t layer;
    logic   push_mix;
    logic   push_zero;
    logic   clear;
    logic   release_pend;
  } dp_cmd_t;

  typedef struct packed {
    logic row_done;
    logic out_room;
  } dp_status_t;

  // exp(-j/16) in Q16 for j = 0 .. 16.
  function automatic logic [16:0] frac_rom(input logic [4:0] j);
    logic [16:0] v;
    case (j)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd61565;
      5'd2:    v = 17'd57835;
      5'd3:    v = 17'd54331;
      5'd4:    v = 17'd51039;
      5'd5:    v = 17'd47947;
      5'd6:    v = 17'd45042;
      5'd7:    v = 17'd42313;
      5'd8:    v = 17'd39749;
      5'd9:    v = 17'd37341;
      5'd10:   v = 17'd35079;
      5'd11:   v = 17'd32954;
      5'd12:   v = 17'd30957;
      5'd13:   v = 17'd29082;
      5'd14:   v = 17'd27320;
      5'd15:   v = 17'd25664;
      default: v = 17'd24109;
    endcase
    return v;
  endfunction

  // exp(-a) in Q16 for a = 0 .. 8.
  function automatic logic [16:0] int_rom(input logic [3:0] a);
    logic [16:0] v;
    case (a)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd24109;
      4'd2:    v = 17'd8869;
      4'd3:    v = 17'd3263;
      4'd4:    v = 17'd1200;
      4'd5:    v = 17'd442;
      4'd6:    v = 17'd162;
      4'd7:    v = 17'd60;
      default: v = 17'd22;
    endcase
    return v;
  endfunction

  // Round half up to Q4.12 and saturate to 16 bits.
  function automatic logic signed [15:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] w;
    logic signed [Q_W-1:0]   q;
    logic signed [15:0]      r;
    w = acc + ACC_W'(2048);
    q = $signed(w[ACC_W-1:12]);
    if (q > Q_W'(32767)) begin
      r = 16'sd32767;
    end else if (q < -Q_W'(32768)) begin
      r = -16'sd32768;
    end else begin
      r = q[15:0];
    end
    return r;
  endfunction

endpackage

/* rtl/core/tcnn_stream_ifs.sv */
// Valid/ready channel interfaces for the sample input and the embedding output.
// Depends on nothing.
`timescale 1ns / 1ps

interface tcnn_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [8:0]         weight_address;
  logic signed [15:0] data_value;
  logic               end_of_sequence;

  modport source(output valid, cmd, weight_address, data_value, end_of_sequence,
                 input ready);
  modport sink(input valid, cmd, weight_address, data_value, end_of_sequence,
               output ready);
endinterface

interface tcnn_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] result_value;
  logic [2:0]         embed_index;
  logic [15:0]        frame_index;
  logic               last_of_run;

  modport source(output valid, result_value, embed_index, frame_index, last_of_run,
                 input ready);
  modport sink(input valid, result_value, embed_index, frame_index, last_of_run,
               output ready);
endinterface

/* rtl/core/tcnn_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module tcnn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/tcnn_ctrl.sv */
// Sequencer of the front end: frame bookkeeping, layer and row order, weight addresses.
// Depends on tcnn_pkg; drives tcnn_datapath through command and status structs.
`timescale 1ns / 1ps

module tcnn_ctrl #(
  parameter int INPUT_CHANNELS    = 4,
  parameter int FILTER_COUNT      = 8,
  parameter int EMBED_SIZE        = 8,
  parameter int FIRST_KERNEL      = 3,
  parameter int DEPTH_KERNEL_TAPS = 3,
  parameter int ADDR_W            = 9,
  parameter int TERM_W            = 4,
  parameter int ROW_W             = 3,
  parameter int CH_W              = 2
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_cmd,
  input  logic                    in_eos,
  output logic                    in_ready,
  input  tcnn_pkg::dp_status_t    status,
  output tcnn_pkg::dp_cmd_t       cmd,
  output logic [CH_W-1:0]         channel,
  output logic [ROW_W-1:0]        row,
  output logic [TERM_W-1:0]       op_index,
  output logic [ADDR_W-1:0]       rd_addr,
  output logic [15:0]             out_frame
);
  import tcnn_pkg::*;

  localparam int R1     = FIRST_KERNEL - 1 - FIRST_KERNEL / 2;
  localparam int R3     = DEPTH_KERNEL_TAPS - 1 - DEPTH_KERNEL_TAPS / 2;
  localparam int OFF_WT = 0;
  localparam int OFF_BT = OFF_WT + FILTER_COUNT * INPUT_CHANNELS * FIRST_KERNEL;
  localparam int OFF_WS = OFF_BT + FILTER_COUNT;
  localparam int OFF_BS = OFF_WS + FILTER_COUNT * FILTER_COUNT;
  localparam int OFF_WD = OFF_BS + FILTER_COUNT;
  localparam int OFF_BD = OFF_WD + FILTER_COUNT * DEPTH_KERNEL_TAPS;
  localparam int OFF_WP = OFF_BD + FILTER_COUNT;
  localparam int OFF_BP = OFF_WP + EMBED_SIZE * FILTER_COUNT;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_FRAME    = 11'b00000000010,
    S_ISSUE    = 11'b00000000100,
    S_WAIT     = 11'b00000001000,
    S_PUSH     = 11'b00000010000,
    S_EMIT     = 11'b00000100000,
    S_AFTER    = 11'b00001000000,
    S_FL_SHIFT = 11'b00010000000,
    S_FL_PUSH  = 11'b00100000000,
    S_CLEAR    = 11'b01000000000,
    S_FINISH   = 11'b10000000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CH_W-1:0]     ch_r, ch_nxt;
  logic                eos_r, eos_nxt;
  logic [7:0]          ffill_r, ffill_nxt;
  logic [7:0]          mfill_r, mfill_nxt;
  logic [15:0]         ofc_r, ofc_nxt;
  layer_t              layer_r, layer_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [TERM_W-1:0]   term_r, term_nxt;
  logic [ADDR_W-1:0]   wptr_r, wptr_nxt;
  logic [2:0]          fl1_r, fl1_nxt;
  logic [2:0]          fl3_r, fl3_nxt;

  logic [TERM_W-1:0]   n_terms;
  logic [ROW_W-1:0]    last_row;
  logic [ADDR_W-1:0]   bias_base;
  logic [7:0]          ffill_inc;
  logic [7:0]          mfill_inc;

  always_comb begin
    case (layer_r)
      LAYER_TEMP: begin
        n_terms   = TERM_W'(FIRST_KERNEL * INPUT_CHANNELS);
        last_row  = ROW_W'(FILTER_COUNT - 1);
        bias_base = ADDR_W'(OFF_BT);
      end
      LAYER_MIX: begin
        n_terms   = TERM_W'(FILTER_COUNT);
        last_row  = ROW_W'(FILTER_COUNT - 1);
        bias_base = ADDR_W'(OFF_BS);
      end
      LAYER_DEPTH: begin
        n_terms   = TERM_W'(DEPTH_KERNEL_TAPS);
        last_row  = ROW_W'(FILTER_COUNT - 1);
        bias_base = ADDR_W'(OFF_BD);
      end
      default: begin
        n_terms   = TERM_W'(FILTER_COUNT);
        last_row  = ROW_W'(EMBED_SIZE - 1);
        bias_base = ADDR_W'(OFF_BP);
      end
    endcase
  end

  assign ffill_inc = (ffill_r == 8'hFF) ? ffill_r : ffill_r + 8'd1;
  assign mfill_inc = (mfill_r == 8'hFF) ? mfill_r : mfill_r + 8'd1;

  assign in_ready  = (state_r == S_IDLE);
  assign channel   = ch_r;
  assign row       = row_r;
  assign op_index  = term_r - TERM_W'(1);
  assign out_frame = ofc_r;

  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    eos_nxt   = eos_r;
    ffill_nxt = ffill_r;
    mfill_nxt = mfill_r;
    ofc_nxt   = ofc_r;
    layer_nxt = layer_r;
    row_nxt   = row_r;
    term_nxt  = term_r;
    wptr_nxt  = wptr_r;
    fl1_nxt   = fl1_r;
    fl3_nxt   = fl3_r;
    cmd       = '0;
    cmd.layer = layer_r;
    rd_addr   = wptr_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_cmd == CMD_WEIGHT) begin
            cmd.weight_we = 1'b1;
          end else begin
            cmd.sample_we    = 1'b1;
            cmd.sample_shift = (ch_r == '0);
            if (ch_r == CH_W'(INPUT_CHANNELS - 1) || in_eos) begin
              ch_nxt    = '0;
              eos_nxt   = in_eos;
              state_nxt = S_FRAME;
            end else begin
              ch_nxt = ch_r + CH_W'(1);
            end
          end
        end
      end
      S_FRAME: begin
        ffill_nxt = ffill_inc;
        if (ffill_inc <= 8'(R1)) begin
          state_nxt = S_AFTER;
        end else begin
          layer_nxt = LAYER_TEMP;
          row_nxt   = '0;
          term_nxt  = '0;
          wptr_nxt  = ADDR_W'(OFF_WT);
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        // A projection row may start only when its result has somewhere to go.
        if (!(layer_r == LAYER_PROJ && term_r == '0 && !status.out_room)) begin
          cmd.issue     = 1'b1;
          cmd.is_bias   = (term_r == '0);
          cmd.last_term = (term_r == n_terms);
          if (term_r == '0) begin
            rd_addr = bias_base + ADDR_W'(row_r);
          end else begin
            wptr_nxt = wptr_r + ADDR_W'(1);
          end
          if (term_r == n_terms) begin
            state_nxt = S_WAIT;
          end else begin
            term_nxt = term_r + TERM_W'(1);
          end
        end
      end
      S_WAIT: begin
        if (status.row_done) begin
          term_nxt = '0;
          row_nxt  = '0;
          if (row_r == last_row) begin
            case (layer_r)
              LAYER_TEMP: begin
                layer_nxt = LAYER_MIX;
                wptr_nxt  = ADDR_W'(OFF_WS);
                state_nxt = S_ISSUE;
              end
              LAYER_MIX: begin
                state_nxt = S_PUSH;
              end
              LAYER_DEPTH: begin
                layer_nxt = LAYER_PROJ;
                wptr_nxt  = ADDR_W'(OFF_WP);
                state_nxt = S_ISSUE;
              end
              default: begin
                ofc_nxt   = ofc_r + 16'd1;
                state_nxt = S_AFTER;
              end
            endcase
          end else begin
            row_nxt   = row_r + ROW_W'(1);
            state_nxt = S_ISSUE;
          end
        end
      end
      S_PUSH: begin
        cmd.push_mix = 1'b1;
        mfill_nxt    = mfill_inc;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        if (mfill_r <= 8'(R3)) begin
          state_nxt = S_AFTER;
        end else begin
          layer_nxt = LAYER_DEPTH;
          row_nxt   = '0;
          term_nxt  = '0;
          wptr_nxt  = ADDR_W'(OFF_WD);
          state_nxt = S_ISSUE;
        end
      end
      S_AFTER: begin
        if (!eos_r) begin
          state_nxt = S_FINISH;
        end else if (fl1_r < 3'(R1)) begin
          state_nxt = S_FL_SHIFT;
        end else if (fl3_r < 3'(R3)) begin
          state_nxt = S_FL_PUSH;
        end else begin
          state_nxt = S_CLEAR;
        end
      end
      S_FL_SHIFT: begin
        cmd.sample_shift = 1'b1;
        fl1_nxt          = fl1_r + 3'd1;
        state_nxt        = S_FRAME;
      end
      S_FL_PUSH: begin
        cmd.push_mix  = 1'b1;
        cmd.push_zero = 1'b1;
        mfill_nxt     = mfill_inc;
        fl3_nxt       = fl3_r + 3'd1;
        state_nxt     = S_EMIT;
      end
      S_CLEAR: begin
        cmd.clear = 1'b1;
        ch_nxt    = '0;
        eos_nxt   = 1'b0;
        ffill_nxt = '0;
        mfill_nxt = '0;
        ofc_nxt   = '0;
        fl1_nxt   = '0;
        fl3_nxt   = '0;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (status.out_room) begin
          cmd.release_pend = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ch_r    <= '0;
      eos_r   <= 1'b0;
      ffill_r <= '0;
      mfill_r <= '0;
      ofc_r   <= '0;
      layer_r <= LAYER_TEMP;
      row_r   <= '0;
      term_r  <= '0;
      wptr_r  <= '0;
      fl1_r   <= '0;
      fl3_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
      eos_r   <= eos_nxt;
      ffill_r <= ffill_nxt;
      mfill_r <= mfill_nxt;
      ofc_r   <= ofc_nxt;
      layer_r <= layer_nxt;
      row_r   <= row_nxt;
      term_r  <= term_nxt;
      wptr_r  <= wptr_nxt;
      fl1_r   <= fl1_nxt;
      fl3_r   <= fl3_nxt;
    end
  end

endmodule

/* rtl/core/tcnn_datapath.sv */
// Datapath: weight RAM, histories, one pipelined multiply-accumulate, rounding,
// a three-stage ELU and the pending/output result registers.
// Depends on tcnn_pkg, tcnn_stream_ifs and tcnn_ram.
`timescale 1ns / 1ps

module tcnn_datapath #(
  parameter int INPUT_CHANNELS    = 4,
  parameter int FILTER_COUNT      = 8,
  parameter int FIRST_KERNEL      = 3,
  parameter int DEPTH_KERNEL_TAPS = 3,
  parameter int WEIGHT_WORDS      = 512,
  parameter int ADDR_W            = 9,
  parameter int TERM_W            = 4,
  parameter int ROW_W             = 3,
  parameter int CH_W              = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tcnn_pkg::dp_cmd_t    cmd,
  output tcnn_pkg::dp_status_t status,
  input  logic [CH_W-1:0]      channel,
  input  logic [ROW_W-1:0]     row,
  input  logic [TERM_W-1:0]    op_index,
  input  logic [ADDR_W-1:0]    rd_addr,
  input  logic [15:0]          out_frame,
  input  logic [8:0]           wr_addr,
  input  logic signed [15:0]   data_value,
  tcnn_out_if.source           out_ch
);
  import tcnn_pkg::*;

  localparam int SAMP_N   = FIRST_KERNEL * INPUT_CHANNELS;
  localparam int NEW_BASE = (FIRST_KERNEL - 1) * INPUT_CHANNELS;
  localparam int SW       = (SAMP_N > 1) ? $clog2(SAMP_N) : 1;
  localparam int FW       = (FILTER_COUNT > 1) ? $clog2(FILTER_COUNT) : 1;
  localparam int KW       = (DEPTH_KERNEL_TAPS > 1) ? $clog2(DEPTH_KERNEL_TAPS) : 1;
  localparam int RAW      = (WEIGHT_WORDS > 1) ? $clog2(WEIGHT_WORDS) : 1;
  localparam int WAW      = (RAW > 9) ? RAW : 9;

  logic signed [15:0] samp_r [SAMP_N];
  logic signed [15:0] samp_nxt [SAMP_N];
  logic signed [15:0] mah_r [DEPTH_KERNEL_TAPS][FILTER_COUNT];
  logic signed [15:0] t1_r [FILTER_COUNT];
  logic signed [15:0] mix_r [FILTER_COUNT];
  logic signed [15:0] dact_r [FILTER_COUNT];

  // Weight store.
  logic [WAW-1:0] wa_ext;
  logic           wr_ok;
  logic [15:0]    ram_rdata;

  assign wa_ext = WAW'(wr_addr);
  assign wr_ok  = (wa_ext < WEIGHT_WORDS);

  tcnn_ram #(
    .WIDTH(16),
    .DEPTH(WEIGHT_WORDS)
  ) u_wram (
    .clk  (clk),
    .we   (cmd.weight_we && wr_ok),
    .waddr(wa_ext[RAW-1:0]),
    .wdata(data_value),
    .raddr(rd_addr[RAW-1:0]),
    .rdata(ram_rdata)
  );

  // Operand selection for the term being issued.
  logic signed [15:0] operand;
  always_comb begin
    case (cmd.layer)
      LAYER_TEMP:  operand = samp_r[op_index[SW-1:0]];
      LAYER_MIX:   operand = t1_r[op_index[FW-1:0]];
      LAYER_DEPTH: operand = mah_r[op_index[KW-1:0]][row[FW-1:0]];
      default:     operand = dact_r[op_index[FW-1:0]];
    endcase
    if (cmd.is_bias) begin
      operand = Q_ONE;
    end
  end

  // Pipeline registers.
  logic               iss_v_r, iss_first_r, iss_last_r, iss_oob_r;
  logic signed [15:0] op_r;
  logic               mul_v_r, mul_first_r, mul_last_r;
  logic signed [31:0] prod_r;
  logic               accl_v_r;
  logic signed [ACC_W-1:0] acc_r;
  logic               rs_v_r;
  logic signed [15:0] rs_r;
  logic               f_v_r, f_neg_r;
  logic signed [15:0] f_x_r;
  logic [16:0]        f_r, ia_r;
  logic               g_v_r, g_neg_r;
  logic signed [15:0] g_x_r;
  logic [16:0]        g_r;

  logic signed [15:0] w_s;
  assign w_s = iss_oob_r ? 16'sd0 : $signed(ram_rdata);

  // First ELU stage: table interpolation of exp over the fractional part.
  logic signed [16:0] xs;
  logic [16:0]        m;
  logic [4:0]         j;
  logic [3:0]         a;
  logic [16:0]        tj, tj1, diff;
  logic [24:0]        corr;
  logic [16:0]        f_val;
  always_comb begin
    xs    = 17'(rs_r);
    m     = 17'(-xs);
    a     = (m[16:12] > 5'd8) ? 4'd8 : m[15:12];
    j     = {1'b0, m[11:8]};
    tj    = frac_rom(j);
    tj1   = frac_rom(j + 5'd1);
    diff  = tj - tj1;
    corr  = 25'(diff) * 25'(m[7:0]) + 25'd128;
    f_val = tj - corr[24:8];
  end

  logic [33:0] g_prod;
  assign g_prod = 34'(f_r) * 34'(ia_r) + 34'd32768;

  logic [16:0]        e_sum;
  logic signed [15:0] elu_val;
  always_comb begin
    e_sum = g_r + 17'd8;
    if (g_neg_r) begin
      elu_val = 16'($signed({3'b000, e_sum[16:4]})) - Q_ONE;
    end else begin
      elu_val = g_x_r;
    end
  end

  logic proj_wb;
  assign proj_wb = rs_v_r && (cmd.layer == LAYER_PROJ);

  // Result registers: a pending result waits until it is known whether it is the
  // last of its run; the output register holds the transaction offered downstream.
  logic               pend_v_r, out_v_r;
  logic signed [15:0] pend_val_r, out_val_r;
  logic [2:0]         pend_emb_r, out_emb_r;
  logic [15:0]        pend_frm_r, out_frm_r;
  logic               out_last_r;

  assign status.row_done = (cmd.layer == LAYER_PROJ) ? rs_v_r : g_v_r;
  assign status.out_room = !pend_v_r || !out_v_r;

  assign out_ch.valid        = out_v_r;
  assign out_ch.result_value = out_val_r;
  assign out_ch.embed_index  = out_emb_r;
  assign out_ch.frame_index  = out_frm_r;
  assign out_ch.last_of_run  = out_last_r;

  always_comb begin
    samp_nxt = samp_r;
    if (cmd.clear) begin
      for (int i = 0; i < SAMP_N; i++) samp_nxt[i] = '0;
    end else begin
      if (cmd.sample_shift) begin
        for (int i = 0; i < NEW_BASE; i++) samp_nxt[i] = samp_r[i + INPUT_CHANNELS];
        for (int i = NEW_BASE; i < SAMP_N; i++) samp_nxt[i] = '0;
      end
      if (cmd.sample_we) begin
        for (int i = 0; i < SAMP_N; i++) begin
          if (i == NEW_BASE + int'(channel)) samp_nxt[i] = data_value;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SAMP_N; i++) samp_r[i] <= '0;
      for (int k = 0; k < DEPTH_KERNEL_TAPS; k++) begin
        for (int f = 0; f < FILTER_COUNT; f++) mah_r[k][f] <= '0;
      end
      iss_v_r  <= 1'b0;
      mul_v_r  <= 1'b0;
      accl_v_r <= 1'b0;
      rs_v_r   <= 1'b0;
      f_v_r    <= 1'b0;
      g_v_r    <= 1'b0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      samp_r <= samp_nxt;
      if (cmd.clear) begin
        for (int k = 0; k < DEPTH_KERNEL_TAPS; k++) begin
          for (int f = 0; f < FILTER_COUNT; f++) mah_r[k][f] <= '0;
        end
      end else if (cmd.push_mix) begin
        for (int k = 0; k < DEPTH_KERNEL_TAPS - 1; k++) mah_r[k] <= mah_r[k + 1];
        for (int f = 0; f < FILTER_COUNT; f++) begin
          mah_r[DEPTH_KERNEL_TAPS - 1][f] <= cmd.push_zero ? 16'sd0 : mix_r[f];
        end
      end
      iss_v_r  <= cmd.issue;
      mul_v_r  <= iss_v_r;
      accl_v_r <= mul_v_r && mul_last_r;
      rs_v_r   <= accl_v_r;
      f_v_r    <= rs_v_r && (cmd.layer != LAYER_PROJ);
      g_v_r    <= f_v_r;

      if (out_v_r && out_ch.ready) begin
        out_v_r <= 1'b0;
      end
      if ((proj_wb || cmd.release_pend) && pend_v_r) begin
        out_v_r <= 1'b1;
      end
      if (proj_wb) begin
        pend_v_r <= 1'b1;
      end else if (cmd.release_pend) begin
        pend_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    iss_first_r <= cmd.is_bias;
    iss_last_r  <= cmd.issue && cmd.last_term;
    iss_oob_r   <= (rd_addr >= WEIGHT_WORDS);
    op_r        <= operand;
    mul_first_r <= iss_first_r;
    mul_last_r  <= iss_last_r;
    prod_r      <= w_s * op_r;
    if (mul_v_r) begin
      acc_r <= (mul_first_r ? ACC_W'(0) : acc_r) + ACC_W'(prod_r);
    end
    rs_r    <= round_sat(acc_r);
    f_r     <= f_val;
    ia_r    <= int_rom(a);
    f_neg_r <= rs_r[15];
    f_x_r   <= rs_r;
    g_r     <= g_prod[32:16];
    g_neg_r <= f_neg_r;
    g_x_r   <= f_x_r;

    if (g_v_r) begin
      case (cmd.layer)
        LAYER_TEMP:  t1_r[row[FW-1:0]]   <= elu_val;
        LAYER_MIX:   mix_r[row[FW-1:0]]  <= elu_val;
        LAYER_DEPTH: dact_r[row[FW-1:0]] <= elu_val;
        default: ;
      endcase
    end
    if ((proj_wb || cmd.release_pend) && pend_v_r) begin
      out_val_r  <= pend_val_r;
      out_emb_r  <= pend_emb_r;
      out_frm_r  <= pend_frm_r;
      out_last_r <= cmd.release_pend;
    end
    if (proj_wb) begin
      pend_val_r <= rs_r;
      pend_emb_r <= 3'(row);
      pend_frm_r <= out_frame;
    end
  end

endmodule

/* rtl/core/temporal_cnn_frontend_inference.sv */
// Temporal CNN front end: temporal conv, ELU, filter mixing, ELU, depthwise conv, ELU,
// projection. Input is taken only while the sequencer is idle. A sample that closes a frame
// leaves the idle state, and the layer rows it starts run through the single
// multiply-accumulate unit and its drain before the next input is taken.
// Weight writes and other samples leave the sequencer idle. Synchronous active-low reset clears all histories and
// counters; the weight RAM is not cleared and must be written before use.
`timescale 1ns / 1ps

module temporal_cnn_frontend_inference #(
  parameter int INPUT_CHANNELS    = 4,
  parameter int FILTER_COUNT      = 8,
  parameter int EMBED_SIZE        = 8,
  parameter int FIRST_KERNEL      = 3,
  parameter int DEPTH_KERNEL_TAPS = 3,
  parameter int WEIGHT_WORDS      = 512
) (
  input logic         clk,
  input logic         rst_n,
  tcnn_in_if.sink     in_ch,
  tcnn_out_if.source  out_ch
);
  import tcnn_pkg::*;

  localparam int TEMP_TERMS = FIRST_KERNEL * INPUT_CHANNELS;
  localparam int MAX_T1     = (TEMP_TERMS > FILTER_COUNT) ? TEMP_TERMS : FILTER_COUNT;
  localparam int MAX_TERMS  = (MAX_T1 > DEPTH_KERNEL_TAPS) ? MAX_T1 : DEPTH_KERNEL_TAPS;
  localparam int TERM_W     = $clog2(MAX_TERMS + 1);
  localparam int ROW_MAX    = (FILTER_COUNT > EMBED_SIZE) ? FILTER_COUNT : EMBED_SIZE;
  localparam int ROW_W      = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1;
  localparam int CH_W       = (INPUT_CHANNELS > 1) ? $clog2(INPUT_CHANNELS) : 1;
  localparam int LAYOUT_END = FILTER_COUNT * TEMP_TERMS + FILTER_COUNT
                            + FILTER_COUNT * FILTER_COUNT + FILTER_COUNT
                            + FILTER_COUNT * DEPTH_KERNEL_TAPS + FILTER_COUNT
                            + EMBED_SIZE * FILTER_COUNT + EMBED_SIZE;
  localparam int ADDR_SPAN  = (LAYOUT_END > WEIGHT_WORDS) ? LAYOUT_END : WEIGHT_WORDS;
  localparam int ADDR_W     = $clog2(ADDR_SPAN + 1);

  dp_cmd_t           cmd;
  dp_status_t        status;
  logic [CH_W-1:0]   channel;
  logic [ROW_W-1:0]  row;
  logic [TERM_W-1:0] op_index;
  logic [ADDR_W-1:0] rd_addr;
  logic [15:0]       out_frame;

  tcnn_ctrl #(
    .INPUT_CHANNELS   (INPUT_CHANNELS),
    .FILTER_COUNT     (FILTER_COUNT),
    .EMBED_SIZE       (EMBED_SIZE),
    .FIRST_KERNEL     (FIRST_KERNEL),
    .DEPTH_KERNEL_TAPS(DEPTH_KERNEL_TAPS),
    .ADDR_W           (ADDR_W),
    .TERM_W           (TERM_W),
    .ROW_W            (ROW_W),
    .CH_W             (CH_W)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_cmd   (in_ch.cmd),
    .in_eos   (in_ch.end_of_sequence),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd),
    .channel  (channel),
    .row      (row),
    .op_index (op_index),
    .rd_addr  (rd_addr),
    .out_frame(out_frame)
  );

  tcnn_datapath #(
    .INPUT_CHANNELS   (INPUT_CHANNELS),
    .FILTER_COUNT     (FILTER_COUNT),
    .FIRST_KERNEL     (FIRST_KERNEL),
    .DEPTH_KERNEL_TAPS(DEPTH_KERNEL_TAPS),
    .WEIGHT_WORDS     (WEIGHT_WORDS),
    .ADDR_W           (ADDR_W),
    .TERM_W           (TERM_W),
    .ROW_W            (ROW_W),
    .CH_W             (CH_W)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .channel   (channel),
    .row       (row),
    .op_index  (op_index),
    .rd_addr   (rd_addr),
    .out_frame (out_frame),
    .wr_addr   (in_ch.weight_address),
    .data_value(in_ch.data_value),
    .out_ch    (out_ch)
  );

  // The end-of-run release only happens when the held result can move out.
  a_release_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.release_pend |-> status.out_room)
    else $error("result released without room in the output register");

  // A projection row never starts while both result registers are occupied.
  a_proj_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.issue && cmd.is_bias && cmd.layer == LAYER_PROJ) |-> status.out_room)
    else $error("projection row started with no room for its result");

  // No transaction is taken on the input while a row is being issued.
  a_no_issue_on_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |-> !cmd.issue)
    else $error("input transaction accepted during row issue");

  // Each row completes with a single-cycle done pulse.
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    status.row_done |=> !status.row_done)
    else $error("row completion held for more than one cycle");

endmodule

/* verif/tcnn_embed_checker.sv */
// Checker for the temporal CNN front end: predicts embedding outputs from the
// observed input transactions and compares them with the output transactions.
// Depends on tcnn_pkg and the stream interfaces in rtl/core/tcnn_stream_ifs.sv.
`timescale 1ns / 1ps

module tcnn_embed_checker (
  input  logic       clk,
  input  logic       rst_n,
  tcnn_in_if         in_ch,
  tcnn_out_if        out_ch,
  output int         errors,
  output int         pending,
  output int         results_seen
);
  import tcnn_pkg::*;

  localparam int NCH = 4;
  localparam int NF  = 8;
  localparam int NE  = 8;
  localparam int K1  = 3;
  localparam int K3  = 3;
  localparam int P1  = K1 - 1 - K1 / 2;
  localparam int P3  = K3 - 1 - K3 / 2;
  localparam int BASE_TW = 0;
  localparam int BASE_TB = BASE_TW + NF * NCH * K1;
  localparam int BASE_MW = BASE_TB + NF;
  localparam int BASE_MB = BASE_MW + NF * NF;
  localparam int BASE_DW = BASE_MB + NF;
  localparam int BASE_DB = BASE_DW + NF * K3;
  localparam int BASE_PW = BASE_DB + NF;
  localparam int BASE_PB = BASE_PW + NE * NF;

  typedef struct {
    logic signed [15:0] value;
    logic [2:0]         idx;
    logic [15:0]        frame;
    logic               last;
  } embed_t;

  // exp(-j/16) and exp(-a) in Q16.
  localparam int unsigned EXP_FRAC [17] = '{65536, 61565, 57835, 54331, 51039, 47947,
    45042, 42313, 39749, 37341, 35079, 32954, 30957, 29082, 27320, 25664, 24109};
  localparam int unsigned EXP_INT [9] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60, 22};

  logic signed [15:0] coeffs [512];
  logic signed [15:0] samples [K1][NCH];
  logic signed [15:0] mixed [K3][NF];
  int                 chan_pos;
  logic [15:0]        emit_frame_no;
  int                 sample_fill;
  int                 mix_fill;
  embed_t             embed_q[$];
  int                 err_cnt;
  int                 seen_cnt;

  assign errors       = err_cnt;
  assign results_seen = seen_cnt;

  function automatic logic signed [15:0] q12_sat(input longint acc);
    longint q;
    q = (acc + 2048) >>> 12;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return 16'(q);
  endfunction

  function automatic logic signed [15:0] elu_q12(input logic signed [15:0] x);
    int unsigned m, a, r, j, fr, f, g, e;
    if (x >= 0) return x;
    m = -int'(x);
    a = m >> 12;
    if (a > 8) a = 8;
    r = m & 4095;
    j = r >> 8;
    fr = r & 255;
    f = EXP_FRAC[j] - (((EXP_FRAC[j] - EXP_FRAC[j + 1]) * fr + 128) >> 8);
    g = int'((longint'(f) * EXP_INT[a] + 32768) >> 16);
    e = (g + 8) >> 4;
    return 16'(int'(e) - 4096);
  endfunction

  function automatic longint coef(input int addr);
    return longint'(coeffs[addr]);
  endfunction

  task automatic clear_history();
    for (int k = 0; k < K1; k++) for (int c = 0; c < NCH; c++) samples[k][c] = '0;
    for (int k = 0; k < K3; k++) for (int f = 0; f < NF; f++) mixed[k][f] = '0;
    chan_pos = 0;
    emit_frame_no = '0;
    sample_fill = 0;
    mix_fill = 0;
  endtask

  task automatic shift_in_zero_frame();
    for (int k = 0; k < K1 - 1; k++) samples[k] = samples[k + 1];
    for (int c = 0; c < NCH; c++) samples[K1 - 1][c] = '0;
  endtask

  task automatic push_mixed(input logic signed [15:0] v [NF]);
    for (int k = 0; k < K3 - 1; k++) mixed[k] = mixed[k + 1];
    mixed[K3 - 1] = v;
    if (mix_fill < 255) mix_fill++;
  endtask

  task automatic project_frame();
    logic signed [15:0] dact [NF];
    longint acc;
    embed_t r;
    if (mix_fill <= P3) return;
    for (int f = 0; f < NF; f++) begin
      acc = coef(BASE_DB + f) * 4096;
      for (int k = 0; k < K3; k++) acc += coef(BASE_DW + f * K3 + k) * longint'(mixed[k][f]);
      dact[f] = elu_q12(q12_sat(acc));
    end
    for (int e = 0; e < NE; e++) begin
      acc = coef(BASE_PB + e) * 4096;
      for (int f = 0; f < NF; f++) acc += coef(BASE_PW + e * NF + f) * longint'(dact[f]);
      r.value = q12_sat(acc);
      r.idx   = 3'(e);
      r.frame = emit_frame_no;
      r.last  = 1'b0;
      embed_q.push_back(r);
    end
    emit_frame_no++;
  endtask

  task automatic close_frame();
    logic signed [15:0] t1 [NF];
    logic signed [15:0] mx [NF];
    longint acc;
    if (sample_fill < 255) sample_fill++;
    if (sample_fill <= P1) return;
    for (int f = 0; f < NF; f++) begin
      acc = coef(BASE_TB + f) * 4096;
      for (int k = 0; k < K1; k++)
        for (int c = 0; c < NCH; c++)
          acc += coef(BASE_TW + f * NCH * K1 + k * NCH + c) * longint'(samples[k][c]);
      t1[f] = elu_q12(q12_sat(acc));
    end
    for (int f = 0; f < NF; f++) begin
      acc = coef(BASE_MB + f) * 4096;
      for (int g = 0; g < NF; g++) acc += coef(BASE_MW + f * NF + g) * longint'(t1[g]);
      mx[f] = elu_q12(q12_sat(acc));
    end
    push_mixed(mx);
    project_frame();
  endtask

  task automatic predict(input logic cmd, input logic [8:0] addr,
                         input logic signed [15:0] val, input logic eos);
    int before_n;
    logic signed [15:0] zeros [NF];
    before_n = embed_q.size();
    for (int f = 0; f < NF; f++) zeros[f] = '0;
    if (cmd == CMD_WEIGHT) begin
      coeffs[addr] = val;
      return;
    end
    if (chan_pos == 0) shift_in_zero_frame();
    samples[K1 - 1][chan_pos] = val;
    if (chan_pos + 1 >= NCH || eos) begin
      chan_pos = 0;
      close_frame();
    end else begin
      chan_pos++;
    end
    if (eos) begin
      for (int v = 0; v < P1; v++) begin
        shift_in_zero_frame();
        close_frame();
      end
      for (int v = 0; v < P3; v++) begin
        push_mixed(zeros);
        project_frame();
      end
      clear_history();
    end
    if (embed_q.size() > before_n) embed_q[embed_q.size() - 1].last = 1'b1;
  endtask

  always @(posedge clk) begin
    embed_t exp_r;
    if (!rst_n) begin
      clear_history();
      embed_q.delete();
      err_cnt = 0;
      seen_cnt = 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        predict(in_ch.cmd, in_ch.weight_address, in_ch.data_value, in_ch.end_of_sequence);
      if (out_ch.valid && out_ch.ready) begin
        seen_cnt++;
        if (embed_q.size() == 0) begin
          $error("unexpected output transaction: value %0d embed %0d frame %0d",
                 out_ch.result_value, out_ch.embed_index, out_ch.frame_index);
          err_cnt++;
        end else begin
          exp_r = embed_q.pop_front();
          if (out_ch.result_value !== exp_r.value) begin
            $error("result_value expected %0d got %0d", exp_r.value, out_ch.result_value);
            err_cnt++;
          end
          if (out_ch.embed_index !== exp_r.idx) begin
            $error("embed_index expected %0d got %0d", exp_r.idx, out_ch.embed_index);
            err_cnt++;
          end
          if (out_ch.frame_index !== exp_r.frame) begin
            $error("frame_index expected %0d got %0d", exp_r.frame, out_ch.frame_index);
            err_cnt++;
          end
          if (out_ch.last_of_run !== exp_r.last) begin
            $error("last_of_run expected %0d got %0d", exp_r.last, out_ch.last_of_run);
            err_cnt++;
          end
        end
      end
    end
    pending <= embed_q.size();
  end

endmodule

/* verif/tb_temporal_cnn_frontend_inference.sv */
// Testbench top for the temporal CNN front end: clock, reset, weight and sample
// stimulus, output back-pressure and the verdict. Depends on tcnn_pkg, the stream
// interfaces, the block itself and tcnn_embed_checker.
`timescale 1ns / 1ps

module tb_temporal_cnn_frontend_inference;
  import tcnn_pkg::*;

  localparam int LAYOUT_WORDS = 280;
  localparam int CYCLE_LIMIT  = 5000000;
  localparam int PHASE_ITEMS  = 40;

  logic clk;
  logic rst_n;
  int   cycles;
  int   tx_idle_pct;
  int   rx_idle_pct;
  int   items_sent;
  int   sequences_sent;
  int   errors;
  int   pending;
  int   results_seen;

  tcnn_in_if  in_bus();
  tcnn_out_if out_bus();

  temporal_cnn_frontend_inference uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  tcnn_embed_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_bus),
    .out_ch       (out_bus),
    .errors       (errors),
    .pending      (pending),
    .results_seen (results_seen)
  );

  always begin
    #2 clk = 1'b0;
    #2 clk = 1'b1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    out_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic signed [15:0] rand_coeff();
    if ($urandom_range(9) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(0, 3072)) - 1536);
  endfunction

  function automatic logic signed [15:0] rand_sample();
    if ($urandom_range(7) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(0, 24576)) - 12288);
  endfunction

  // Valid is only lowered when a gap is inserted, so it never falls and rises
  // within one time step between back-to-back transactions.
  task automatic send(input logic cmd, input logic [8:0] addr,
                      input logic signed [15:0] val, input logic eos);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_bus.valid           <= 1'b1;
    in_bus.cmd             <= cmd;
    in_bus.weight_address  <= addr;
    in_bus.data_value      <= val;
    in_bus.end_of_sequence <= eos;
    do @(posedge clk); while (!in_bus.ready);
    items_sent++;
  endtask

  task automatic load_all_coeffs();
    for (int a = 0; a < LAYOUT_WORDS; a++) send(CMD_WEIGHT, 9'(a), rand_coeff(), 1'b0);
  endtask

  // One sequence of whole frames; an early end cuts the last frame short.
  task automatic run_sequence(input int frames, input bit early_end);
    int last_ch;
    last_ch = early_end ? $urandom_range(0, 2) : 3;
    for (int fr = 0; fr < frames; fr++) begin
      for (int c = 0; c < 4; c++) begin
        if (fr == frames - 1 && c > last_ch) break;
        send(CMD_SAMPLE, 9'($urandom), rand_sample(),
             (fr == frames - 1 && c == last_ch));
      end
    end
    sequences_sent++;
  endtask

  task automatic random_phase();
    int start;
    start = items_sent;
    while (items_sent - start < PHASE_ITEMS) begin
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 6))
          send(CMD_WEIGHT, 9'($urandom_range(0, LAYOUT_WORDS - 1)), rand_coeff(),
               1'($urandom));
      end
      run_sequence($urandom_range(1, 8), $urandom_range(4) == 0);
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cycles = 0;
    items_sent = 0;
    sequences_sent = 0;
    tx_idle_pct = 17;
    rx_idle_pct = 70;
    in_bus.valid = 1'b0;
    in_bus.cmd = CMD_WEIGHT;
    in_bus.weight_address = '0;
    in_bus.data_value = '0;
    in_bus.end_of_sequence = 1'b0;
    out_bus.ready = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: every layout word written first, then store addresses
    // outside the layout, a weight write carrying the end flag, and sample
    // extremes with single-sample and early-ending sequences.
    load_all_coeffs();
    send(CMD_WEIGHT, 9'd511, 16'sh7fff, 1'b0);
    send(CMD_WEIGHT, 9'd300, -16'sd32768, 1'b1);
    send(CMD_WEIGHT, 9'd0, 16'sh7fff, 1'b1);
    send(CMD_WEIGHT, 9'd1, -16'sd32768, 1'b0);
    send(CMD_SAMPLE, 9'd0, -16'sd32768, 1'b1);
    send(CMD_SAMPLE, 9'h1ff, 16'sh7fff, 1'b0);
    send(CMD_SAMPLE, 9'd0, -16'sd32768, 1'b0);
    send(CMD_SAMPLE, 9'd0, 16'sd0, 1'b0);
    send(CMD_SAMPLE, 9'd0, -16'sd1, 1'b0);
    send(CMD_SAMPLE, 9'd0, -16'sd32768, 1'b0);
    send(CMD_SAMPLE, 9'd0, -16'sd32768, 1'b1);
    send(CMD_SAMPLE, 9'd0, 16'sh7fff, 1'b0);
    send(CMD_SAMPLE, 9'd0, 16'sh7fff, 1'b0);
    send(CMD_SAMPLE, 9'd0, 16'sh7fff, 1'b0);
    send(CMD_SAMPLE, 9'd0, 16'sh7fff, 1'b1);

    random_phase();
    tx_idle_pct = 70;
    rx_idle_pct = 17;
    random_phase();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_phase();

    in_bus.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (1500) @(posedge clk);
    $display("Sent %0d input transactions in %0d sequences; checked %0d embedding outputs.",
             items_sent, sequences_sent, results_seen);
    $display("Idle mixes covered: sender-heavy, receiver-heavy and none.");
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/tcnn_pkg.sv
rtl/core/tcnn_stream_ifs.sv
rtl/core/tcnn_ram.sv
rtl/core/tcnn_ctrl.sv
rtl/core/tcnn_datapath.sv
rtl/core/temporal_cnn_frontend_inference.sv
verif/tcnn_embed_checker.sv
verif/tb_temporal_cnn_frontend_inference.sv
